@@ rtl/kvt_pkg.sv @@
package kvt_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned KEY_W        = 32;
    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned STATUS_W     = 3;
    localparam int unsigned ENTRY_IDX_W  = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4
    } t_status;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DECIDE,
        S_RESP
    } t_state;

endpackage

@@ rtl/key_value_table_top.sv @@
// Associative table of up to CAPACITY signed 32-bit key/value pairs. A write
// beat updates the value of a stored key or appends a new pair (dropped with
// status full when the table is full); a lookup beat returns hit, slot and
// value. Each beat gives exactly one result beat. Beats enter a two-deep
// queue and are carried out one at a time by a search engine that reads the
// stored keys in slot order from its single key-memory port, each read
// followed by a compare, up to the slot of the match or the last filled slot
// on a miss, and reads no key at all on an empty table. The output holds one
// finished result while the next item is searched.
module key_value_table_top #(
    parameter int unsigned CAPACITY = kvt_pkg::CAPACITY_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_req_type,
    input  logic signed [kvt_pkg::KEY_W-1:0]       i_key,
    input  logic signed [kvt_pkg::VALUE_W-1:0]     i_value,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [kvt_pkg::STATUS_W-1:0]           o_status,
    output logic                                   o_hit,
    output logic [kvt_pkg::ENTRY_IDX_W-1:0]        o_entry_index,
    output logic signed [kvt_pkg::VALUE_W-1:0]     o_read_value
);

    logic          w_q_valid;
    logic          w_q_pop;
    kvt_pkg::t_req w_q_req;

    kvt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_key      (i_key),
        .i_value    (i_value),
        .o_q_valid  (w_q_valid),
        .i_q_pop    (w_q_pop),
        .o_q_req    (w_q_req)
    );

    kvt_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .o_q_pop       (w_q_pop),
        .i_q_req       (w_q_req),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_hit         (o_hit),
        .o_entry_index (o_entry_index),
        .o_read_value  (o_read_value)
    );

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("queue popped while empty");

    a_hit_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit == (o_status == kvt_pkg::ST_UPDATED ||
                               o_status == kvt_pkg::ST_HIT)))
        else $error("hit flag disagrees with status");

    a_value_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != kvt_pkg::ST_HIT) |-> (o_read_value == '0))
        else $error("read value set without a lookup hit");

    a_no_index_when_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == kvt_pkg::ST_MISS || o_status == kvt_pkg::ST_FULL)
        |-> (o_entry_index == '0))
        else $error("entry index set on miss or full drop");
`endif

endmodule

@@ rtl/kvt_front.sv @@
module kvt_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_req_type,
    input  logic signed [kvt_pkg::KEY_W-1:0]    i_key,
    input  logic signed [kvt_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_q_valid,
    input  logic                                i_q_pop,
    output kvt_pkg::t_req                       o_q_req
);

    kvt_pkg::t_req r_buf [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;
    kvt_pkg::t_req w_req;

    always_comb begin
        w_req.op    = i_req_type ? kvt_pkg::OP_LOOKUP : kvt_pkg::OP_WRITE;
        w_req.key   = i_key;
        w_req.value = i_value;
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_buf[r_rp];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_req;
        end
    end

endmodule

@@ rtl/kvt_back.sv @@
module kvt_back #(
    parameter int unsigned CAPACITY = kvt_pkg::CAPACITY_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_q_valid,
    output logic                                   o_q_pop,
    input  kvt_pkg::t_req                          i_q_req,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [kvt_pkg::STATUS_W-1:0]           o_status,
    output logic                                   o_hit,
    output logic [kvt_pkg::ENTRY_IDX_W-1:0]        o_entry_index,
    output logic signed [kvt_pkg::VALUE_W-1:0]     o_read_value
);

    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [kvt_pkg::KEY_W-1:0]   r_key_mem [CAPACITY];
    logic [kvt_pkg::VALUE_W-1:0] r_val_mem [CAPACITY];

    kvt_pkg::t_state r_state;
    kvt_pkg::t_state n_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    kvt_pkg::t_req   r_req;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   n_idx;
    logic [IW-1:0]   r_slot;
    logic            r_found;
    logic [kvt_pkg::KEY_W-1:0]   r_kdata;
    logic [kvt_pkg::VALUE_W-1:0] r_vdata;

    kvt_pkg::t_status                r_res_status;
    kvt_pkg::t_status                n_res_status;
    logic                            r_res_hit;
    logic                            n_res_hit;
    logic [kvt_pkg::ENTRY_IDX_W-1:0] r_res_idx;
    logic [kvt_pkg::ENTRY_IDX_W-1:0] n_res_idx;
    logic                            r_res_rd;
    logic                            n_res_rd;

    logic                            r_out_valid;
    logic [kvt_pkg::STATUS_W-1:0]    r_out_status;
    logic                            r_out_hit;
    logic [kvt_pkg::ENTRY_IDX_W-1:0] r_out_idx;
    logic [kvt_pkg::VALUE_W-1:0]     r_out_value;

    logic          w_pop;
    logic          w_match;
    logic          w_last;
    logic          w_load;
    logic          w_full;
    logic          w_wr_key;
    logic          w_wr_val;
    logic [IW-1:0] w_ins_idx;
    logic [IW-1:0] w_wr_idx;

    assign w_match   = (r_kdata == r_req.key);
    assign w_last    = ((CW'(r_idx) + CW'(1)) == r_count);
    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_ins_idx = IW'(r_count);
    assign w_wr_idx  = r_found ? r_slot : w_ins_idx;

    always_comb begin
        n_state = r_state;
        case (r_state)
            kvt_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_state = (r_count == '0) ? kvt_pkg::S_DECIDE : kvt_pkg::S_READ;
                end
            end
            kvt_pkg::S_READ: begin
                n_state = kvt_pkg::S_CMP;
            end
            kvt_pkg::S_CMP: begin
                n_state = (w_match || w_last) ? kvt_pkg::S_DECIDE : kvt_pkg::S_READ;
            end
            kvt_pkg::S_DECIDE: begin
                n_state = kvt_pkg::S_RESP;
            end
            kvt_pkg::S_RESP: begin
                if (!r_out_valid || i_ready) begin
                    n_state = kvt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kvt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_pop        = 1'b0;
        w_load       = 1'b0;
        w_wr_key     = 1'b0;
        w_wr_val     = 1'b0;
        n_idx        = r_idx;
        n_count      = r_count;
        n_res_status = kvt_pkg::ST_MISS;
        n_res_hit    = 1'b0;
        n_res_idx    = '0;
        n_res_rd     = 1'b0;
        case (r_state)
            kvt_pkg::S_IDLE: begin
                w_pop = i_q_valid;
                n_idx = '0;
            end
            kvt_pkg::S_CMP: begin
                if (!w_match && !w_last) begin
                    n_idx = r_idx + IW'(1);
                end
            end
            kvt_pkg::S_DECIDE: begin
                if (r_req.op == kvt_pkg::OP_LOOKUP) begin
                    if (r_found) begin
                        n_res_status = kvt_pkg::ST_HIT;
                        n_res_hit    = 1'b1;
                        n_res_idx    = kvt_pkg::ENTRY_IDX_W'(r_slot);
                        n_res_rd     = 1'b1;
                    end
                end else if (r_found) begin
                    n_res_status = kvt_pkg::ST_UPDATED;
                    n_res_hit    = 1'b1;
                    n_res_idx    = kvt_pkg::ENTRY_IDX_W'(r_slot);
                    w_wr_val     = 1'b1;
                end else if (!w_full) begin
                    n_res_status = kvt_pkg::ST_INSERTED;
                    n_res_idx    = kvt_pkg::ENTRY_IDX_W'(w_ins_idx);
                    w_wr_key     = 1'b1;
                    w_wr_val     = 1'b1;
                    n_count      = r_count + CW'(1);
                end else begin
                    n_res_status = kvt_pkg::ST_FULL;
                end
            end
            kvt_pkg::S_RESP: begin
                w_load = !r_out_valid || i_ready;
            end
            default: begin
                w_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kvt_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (w_pop) begin
            r_req   <= i_q_req;
            r_found <= 1'b0;
        end
        if (r_state == kvt_pkg::S_CMP && w_match) begin
            r_found <= 1'b1;
            r_slot  <= r_idx;
        end
        if (r_state == kvt_pkg::S_DECIDE) begin
            r_res_status <= n_res_status;
            r_res_hit    <= n_res_hit;
            r_res_idx    <= n_res_idx;
            r_res_rd     <= n_res_rd;
        end
        if (w_load) begin
            r_out_status <= r_res_status;
            r_out_hit    <= r_res_hit;
            r_out_idx    <= r_res_idx;
            r_out_value  <= r_res_rd ? r_vdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_key) begin
            r_key_mem[w_ins_idx] <= r_req.key;
        end
        if (w_wr_val) begin
            r_val_mem[w_wr_idx] <= r_req.value;
        end
        r_kdata <= r_key_mem[r_idx];
        r_vdata <= r_val_mem[r_slot];
    end

    assign o_q_pop       = w_pop;
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_hit         = r_out_hit;
    assign o_entry_index = r_out_idx;
    assign o_read_value  = r_out_value;

endmodule
